// ===== design/sfr_pkg.sv =====
// Package for the sensor frame receiver: frame constants, status codes and
// the types shared by the parser, the decoder and the top level. No dependencies.
`default_nettype none

package sfr_pkg;

   localparam int POS_W     = 9;
   localparam int CAP_DEPTH = 12;
   localparam int CAP_IDX_W = 4;

   localparam logic [7:0] SYNC_BYTE = 8'h10;
   localparam logic [7:0] TYPE_BYTE = 8'hF8;
   localparam logic [7:0] CMD_ODOM  = 8'hAA;
   localparam logic [7:0] CMD_RANGE = 8'hBB;

   localparam logic [POS_W-1:0] POS_HUNT      = 9'd0;
   localparam logic [POS_W-1:0] POS_LENGTH    = 9'd1;
   localparam logic [POS_W-1:0] POS_FIRST_CAP = 9'd2;
   localparam logic [POS_W-1:0] POS_LAST_CAP  = 9'd13;

   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_ODOM    = 3'd1;
   localparam logic [2:0] ST_RANGE   = 3'd2;
   localparam logic [2:0] ST_OTHER   = 3'd3;
   localparam logic [2:0] ST_BADSUM  = 3'd4;
   localparam logic [2:0] ST_BADTYPE = 3'd5;

   typedef logic [CAP_DEPTH-1:0][7:0] cap_array_type;

   typedef struct packed {
      logic          frame_end;
      logic          sum_ok;
      cap_array_type capture;
   } parse_type;

   typedef struct packed {
      logic [15:0]      yaw;
      logic [31:0]      left;
      logic [31:0]      right;
      logic [5:0][7:0]  ranges;
      logic [2:0]       status;
   } decode_type;

endpackage

`default_nettype wire

// ===== design/sensor_frame_receiver.sv =====
// Sensor frame receiver top level: parser, decoder and the result register.
// An accepted byte's result word is on rsp_ in the next cycle; throughput is one byte
// per cycle unless rsp_ready stalls; the result register refills in the cycle it drains.
// Reset: synchronous; clears position, length, sum, capture store, held values
// and the result valid flag.
`default_nettype none

module sensor_frame_receiver (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [15:0]        rsp_yaw_raw,
   output      logic signed [31:0] rsp_left_odometer,
   output      logic signed [31:0] rsp_right_odometer,
   output      logic [7:0]         rsp_range_one,
   output      logic [7:0]         rsp_range_two,
   output      logic [7:0]         rsp_range_three,
   output      logic [7:0]         rsp_range_four,
   output      logic [7:0]         rsp_range_five,
   output      logic [7:0]         rsp_range_six,
   output      logic [2:0]         rsp_frame_status
);
   import sfr_pkg::*;

   logic       accept;
   parse_type  parse;
   decode_type result;
   decode_type rsp_ff;
   logic       rsp_valid_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   sfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .parse   (parse)
   );

   sfr_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .parse  (parse),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_yaw_raw        = rsp_ff.yaw;
   assign rsp_left_odometer  = $signed(rsp_ff.left);
   assign rsp_right_odometer = $signed(rsp_ff.right);
   assign rsp_range_one      = rsp_ff.ranges[0];
   assign rsp_range_two      = rsp_ff.ranges[1];
   assign rsp_range_three    = rsp_ff.ranges[2];
   assign rsp_range_four     = rsp_ff.ranges[3];
   assign rsp_range_five     = rsp_ff.ranges[4];
   assign rsp_range_six      = rsp_ff.ranges[5];
   assign rsp_frame_status   = rsp_ff.status;

   // A byte that does not end a frame always reports no status.
   a_mid_frame_none: assert property (@(posedge clock) disable iff (reset)
      (accept && !parse.frame_end) |=> (rsp_frame_status == ST_NONE))
      else $error("status reported on a byte that does not end a frame");

   // A frame ending on a checksum mismatch reports the bad checksum code.
   a_badsum: assert property (@(posedge clock) disable iff (reset)
      (accept && parse.frame_end && !parse.sum_ok) |=> (rsp_frame_status == ST_BADSUM))
      else $error("checksum mismatch not reported");

   // Every accepted byte leaves a result word waiting in the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte produced no result word");

   // After reset the result register is empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== design/sfr_parser.sv =====
// Frame parser: tracks the byte position, length and running checksum, and
// keeps the capture store of frame positions two to thirteen. Uses sfr_pkg.
`default_nettype none

module sfr_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   output      sfr_pkg::parse_type parse
);
   import sfr_pkg::*;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           sum_ff, sum_in;
   cap_array_type        cap_ff, cap_in;
   logic [POS_W-1:0]     end_pos;
   logic [POS_W-1:0]     pos_off;
   logic [CAP_IDX_W-1:0] cap_idx;
   logic                 frame_end;

   assign end_pos = {1'b0, len_ff} + POS_FIRST_CAP;
   assign pos_off = pos_ff - POS_FIRST_CAP;
   assign cap_idx = pos_off[CAP_IDX_W-1:0];

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      cap_in    = cap_ff;
      frame_end = 1'b0;
      if (pos_ff == POS_HUNT) begin
         if (rx_byte == SYNC_BYTE) begin
            pos_in = POS_LENGTH;
            sum_in = 8'd0;
         end
      end else if (pos_ff == POS_LENGTH) begin
         len_in = rx_byte;
         sum_in = rx_byte;
         pos_in = POS_FIRST_CAP;
      end else begin
         if (pos_ff <= POS_LAST_CAP) begin
            cap_in[cap_idx] = rx_byte;
         end
         if (pos_ff >= end_pos) begin
            frame_end = 1'b1;
            pos_in    = POS_HUNT;
         end else begin
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 9'd1;
         end
      end
   end

   assign parse.frame_end = frame_end;
   assign parse.sum_ok    = (rx_byte == sum_ff);
   assign parse.capture   = cap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         len_ff <= 8'd0;
         sum_ff <= 8'd0;
         cap_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         sum_ff <= sum_in;
         cap_ff <= cap_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sfr_decoder.sv =====
// Frame decoder: checks checksum, type and command of a finished frame and keeps the
// held heading, odometers and ranges. Uses sfr_pkg and the parser's outputs.
`default_nettype none

module sfr_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire sfr_pkg::parse_type parse,
   output      sfr_pkg::decode_type result
);
   import sfr_pkg::*;

   logic [15:0]     yaw_ff, yaw_in;
   logic [31:0]     left_ff, left_in;
   logic [31:0]     right_ff, right_in;
   logic [5:0][7:0] range_ff, range_in;
   logic [2:0]      status;
   cap_array_type   cap;

   assign cap = parse.capture;

   always_comb begin
      yaw_in   = yaw_ff;
      left_in  = left_ff;
      right_in = right_ff;
      range_in = range_ff;
      status   = ST_NONE;
      if (parse.frame_end) begin
         if (!parse.sum_ok) begin
            status = ST_BADSUM;
         end else if (cap[0] != TYPE_BYTE) begin
            status = ST_BADTYPE;
         end else begin
            case (cap[1])
               CMD_ODOM: begin
                  status   = ST_ODOM;
                  yaw_in   = {cap[3], cap[2]};
                  left_in  = {cap[7], cap[6], cap[5], cap[4]};
                  right_in = {cap[11], cap[10], cap[9], cap[8]};
               end
               CMD_RANGE: begin
                  status   = ST_RANGE;
                  range_in = {cap[7], cap[6], cap[5], cap[4], cap[3], cap[2]};
               end
               default: begin
                  status = ST_OTHER;
               end
            endcase
         end
      end
   end

   assign result.yaw    = yaw_in;
   assign result.left   = left_in;
   assign result.right  = right_in;
   assign result.ranges = range_in;
   assign result.status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= 16'd0;
         left_ff  <= 32'd0;
         right_ff <= 32'd0;
         range_ff <= '0;
      end else if (accept) begin
         yaw_ff   <= yaw_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         range_ff <= range_in;
      end
   end

endmodule

`default_nettype wire
